### rtl/core/dlr_pkg.sv
// Shared types and constants for the deque with lazy reverse.
package dlr_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VAL_W = 16;
	localparam int CMD_W = 3;
	localparam int KIND_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR   = 3'd0,
		CMD_PUSH    = 3'd1,
		CMD_REVERSE = 3'd2,
		CMD_DELETE  = 3'd3,
		CMD_FINISH  = 3'd4
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ELEM  = 2'd0,
		KIND_ERROR = 2'd1,
		KIND_EMPTY = 2'd2
	} kind_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_DRAIN = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic apply;   // execute the request on the input port
		logic issue;   // read the next drain element
	} dlr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic s1_free;
		logic empty;
		logic failed;
		logic last_idx;
	} dlr_stat_t;

endpackage

### rtl/core/deque_with_lazy_reverse.sv
// Top level of the deque with lazy reverse: controller plus datapath.
//
// Input channel (in_valid/in_ready, cmd, value) takes one request per cycle:
// clear, push, reverse, delete front, finish. Clear, push, reverse and a
// good delete produce no result and finish in the cycle they are accepted.
// Output channel (out_valid/out_ready) carries results: kind, value_res,
// overflow_seen and last, which marks the final result of one request.
// A delete on an empty queue emits one error and ignores everything but
// clear afterwards. A finish on an empty queue emits one empty marker.
// A finish on N values drains them in logical order, one per cycle when
// out_ready stays high, through the store's registered read port, a read
// stage and the output register; input is held off until the last read is
// issued. The first read is issued once the finish is accepted; an error or
// empty marker is loaded into the read stage when its request is accepted.
// When the receiver stalls, the read stage and output register fill and then
// in_ready drops; no result is lost. Reset empties the queue, clears the
// reverse, failed and overflow flags; store contents stay undefined.
module deque_with_lazy_reverse
	import dlr_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [VAL_W-1:0]  value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [KIND_W-1:0] kind,
	output logic [VAL_W-1:0]  value_res,
	output logic              overflow_seen,
	output logic              last
);

	dlr_cmd_t  ctl;
	dlr_stat_t stat;

	// Sequence requests and the drain.
	dlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// Hold the ring store, pointers, flags and the result path.
	dlr_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cmd           (cmd),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.value_res     (value_res),
		.overflow_seen (overflow_seen),
		.last          (last)
	);

endmodule

### rtl/core/dlr_ctrl.sv
// Controller state machine: request acceptance and drain sequencing.
module dlr_ctrl
	import dlr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] cmd,
	output logic             in_ready,
	input  dlr_stat_t        stat,
	output dlr_cmd_t         ctl
);

	state_t state_q, state_d;
	logic   accept;
	logic   start_drain;

	assign accept = in_valid && in_ready;
	assign start_drain = accept && (cmd == CMD_FINISH) && !stat.failed && !stat.empty;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start_drain)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (stat.s1_free && stat.last_idx)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		ctl.apply = 1'b0;
		ctl.issue = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = stat.s1_free;
				ctl.apply = in_valid && stat.s1_free;
			end
			ST_DRAIN: begin
				ctl.issue = stat.s1_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

### rtl/core/dlr_dp.sv
// Datapath: ring store, pointers, flags, read stage and output register.
module dlr_dp
	import dlr_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dlr_cmd_t          ctl,
	output dlr_stat_t         stat,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [VAL_W-1:0]  value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [KIND_W-1:0] kind,
	output logic [VAL_W-1:0]  value_res,
	output logic              overflow_seen,
	output logic              last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] TOP_A   = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	logic [VAL_W-1:0] mem [DEPTH];

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          rev_q, failed_q, ovf_q;

	logic          s1_valid_q;
	kind_t         s1_kind_q;
	logic          s1_last_q, s1_mem_q, s1_ovf_q;
	logic [VAL_W-1:0] rd_data_q;

	logic          out_valid_q;
	kind_t         out_kind_q;
	logic [VAL_W-1:0] out_value_q;
	logic          out_ovf_q, out_last_q;

	logic          out_load, s1_free;
	logic          full, empty;
	logic [AW-1:0] head_inc, head_dec, tail, wr_addr, rd_addr;
	logic [AW:0]   tail_sum, rd_sum;
	logic [CW-1:0] off;
	logic          push_ok, emit_err, emit_empty, last_idx;
	cmd_t          op;

	assign op    = cmd_t'(cmd);
	assign full  = (count_q == DEPTH_C);
	assign empty = (count_q == '0);

	assign head_inc = (head_q == TOP_A) ? '0 : head_q + AW'(1);
	assign head_dec = (head_q == '0) ? TOP_A : head_q - AW'(1);

	// Physical tail: head plus count, wrapped once.
	assign tail_sum = {1'b0, head_q} + {1'b0, count_q[AW-1:0]};
	assign tail     = (tail_sum >= DEPTH_A) ? AW'(tail_sum - DEPTH_A) : tail_sum[AW-1:0];
	assign wr_addr  = rev_q ? head_dec : tail;

	// Drain offset runs backward from the physical back when reversed.
	assign off     = rev_q ? (count_q - ONE_C - idx_q) : idx_q;
	assign rd_sum  = {1'b0, head_q} + {1'b0, off[AW-1:0]};
	assign rd_addr = (rd_sum >= DEPTH_A) ? AW'(rd_sum - DEPTH_A) : rd_sum[AW-1:0];
	assign last_idx = (idx_q == count_q - ONE_C);

	assign push_ok    = ctl.apply && !failed_q && (op == CMD_PUSH) && !full;
	assign emit_err   = ctl.apply && !failed_q && (op == CMD_DELETE) && empty;
	assign emit_empty = ctl.apply && !failed_q && (op == CMD_FINISH) && empty;

	assign out_load = s1_valid_q && (!out_valid_q || out_ready);
	assign s1_free  = !s1_valid_q || out_load;

	assign stat.s1_free  = s1_free;
	assign stat.empty    = empty;
	assign stat.failed   = failed_q;
	assign stat.last_idx = last_idx;

	always_ff @(posedge clk) begin
		if (push_ok)
			mem[wr_addr] <= value;
		if (ctl.issue)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			rev_q    <= 1'b0;
			failed_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else if (ctl.apply) begin
			if (op == CMD_CLEAR) begin
				head_q   <= '0;
				count_q  <= '0;
				rev_q    <= 1'b0;
				failed_q <= 1'b0;
				ovf_q    <= 1'b0;
			end else if (!failed_q) begin
				unique case (op)
					CMD_PUSH: begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							if (rev_q)
								head_q <= head_dec;
							count_q <= count_q + ONE_C;
						end
					end
					CMD_REVERSE: rev_q <= !rev_q;
					CMD_DELETE: begin
						if (empty) begin
							failed_q <= 1'b1;
						end else begin
							if (!rev_q)
								head_q <= head_inc;
							count_q <= count_q - ONE_C;
						end
					end
					CMD_FINISH: idx_q <= '0;
					default: ;
				endcase
			end
		end else if (ctl.issue) begin
			idx_q <= idx_q + ONE_C;
			if (last_idx)
				count_q <= '0;
		end
	end

	// Read stage control and output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.issue || emit_err || emit_empty)
				s1_valid_q <= 1'b1;
			else if (out_load)
				s1_valid_q <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Result payload; no reset needed.
	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			s1_kind_q <= KIND_ELEM;
			s1_last_q <= last_idx;
			s1_mem_q  <= 1'b1;
			s1_ovf_q  <= ovf_q;
		end else if (emit_err || emit_empty) begin
			s1_kind_q <= emit_err ? KIND_ERROR : KIND_EMPTY;
			s1_last_q <= 1'b1;
			s1_mem_q  <= 1'b0;
			s1_ovf_q  <= ovf_q;
		end
		if (out_load) begin
			out_kind_q  <= s1_kind_q;
			out_value_q <= s1_mem_q ? rd_data_q : '0;
			out_ovf_q   <= s1_ovf_q;
			out_last_q  <= s1_last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_kind_q;
	assign value_res     = out_value_q;
	assign overflow_seen = out_ovf_q;
	assign last          = out_last_q;

endmodule

### tb/deque_with_lazy_reverse_test.sv
// Self-checking testbench for the deque with lazy reverse: driver, monitor and shadow deque.
module deque_with_lazy_reverse_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dlr_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	// Cycles with no handshake on either side before the run is declared hung.
	localparam int QUIET_LIMIT = 5000;
	// Length of the one long receiver hold-off.
	localparam int RX_HOLD_CYCLES = 300;
	// Command codes the block must ignore.
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	typedef enum int {
		RX_OPEN,    // always ready
		RX_HALF,    // ready on about half the cycles
		RX_SPARSE   // ready on about a quarter of the cycles
	} rx_mode_t;

	// One request waiting to go out on the input channel.
	typedef struct {
		logic [CMD_W-1:0] op;
		logic [VAL_W-1:0] val;
		bit               wait_idle;  // hold it back until every result is in
		bit               hold_rx;    // start the long receiver hold-off on acceptance
	} request_t;

	// One predicted result.
	typedef struct {
		kind_t            kind;
		logic [VAL_W-1:0] val;
		logic             ovf;
		logic             last;
	} result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [CMD_W-1:0] cmd = CMD_CLEAR;
	logic [VAL_W-1:0] value = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [KIND_W-1:0] kind;
	logic [VAL_W-1:0] value_res;
	logic             overflow_seen;
	logic             last;

	deque_with_lazy_reverse DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.value_res    (value_res),
		.overflow_seen(overflow_seen),
		.last         (last)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow deque: ring store, head, count and the three flags.
	// ------------------------------------------------------------------
	logic [VAL_W-1:0] dq_store [DEPTH];
	int               dq_head = 0;
	int               dq_count = 0;
	bit               dq_rev = 1'b0;
	bit               dq_failed = 1'b0;
	bit               dq_ovf = 1'b0;

	request_t request_q[$];       // requests not yet offered
	result_t  future_results[$];  // results the deque owes, oldest first

	// Append a request at the tail of the pending list.
	function automatic void add_request(input request_t r);
		request_q.insert(request_q.size(), r);
	endfunction

	// Take the oldest pending request.
	function automatic request_t next_request();
		next_request = request_q[0];
		request_q.delete(0);
	endfunction

	// Append a result the deque now owes.
	function automatic void owe_result(input result_t r);
		future_results.insert(future_results.size(), r);
	endfunction

	// Take the oldest owed result.
	function automatic result_t take_result();
		take_result = future_results[0];
		future_results.delete(0);
	endfunction

	// Apply one accepted request to the shadow deque and queue what it emits.
	function automatic void deque_apply(input logic [CMD_W-1:0] op,
		input logic [VAL_W-1:0] val);
		int off;
		if (op == CMD_CLEAR) begin
			// Clear always acts, even in the failed state; store is left alone.
			dq_head = 0;
			dq_count = 0;
			dq_rev = 1'b0;
			dq_failed = 1'b0;
			dq_ovf = 1'b0;
		end else if (!dq_failed) begin
			case (op)
				CMD_PUSH: begin
					if (dq_count == DEPTH) begin
						// Full: drop the value, remember the loss.
						dq_ovf = 1'b1;
					end else if (!dq_rev) begin
						dq_store[(dq_head + dq_count) % DEPTH] = val;
						dq_count++;
					end else begin
						// Reversed: the logical back sits just before the physical front.
						dq_head = (dq_head + DEPTH - 1) % DEPTH;
						dq_store[dq_head] = val;
						dq_count++;
					end
				end
				CMD_REVERSE: dq_rev = !dq_rev;
				CMD_DELETE: begin
					if (dq_count == 0) begin
						// Delete on empty: one error, then freeze until clear.
						dq_failed = 1'b1;
						owe_result(result_t'{KIND_ERROR, '0, dq_ovf, 1'b1});
					end else begin
						if (!dq_rev)
							dq_head = (dq_head + 1) % DEPTH;
						dq_count--;
					end
				end
				CMD_FINISH: begin
					if (dq_count == 0) begin
						owe_result(result_t'{KIND_EMPTY, '0, dq_ovf, 1'b1});
					end else begin
						// Drain in logical order; head and orientation survive.
						for (int i = 0; i < dq_count; i++) begin
							off = dq_rev ? (dq_count - 1 - i) : i;
							owe_result(result_t'{KIND_ELEM,
								dq_store[(dq_head + off) % DEPTH], dq_ovf,
								(i == dq_count - 1)});
						end
						dq_count = 0;
					end
				end
				default: ;  // spare codes do nothing
			endcase
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers requests in bursts separated by random gaps.
	// ------------------------------------------------------------------
	request_t offer = '{CMD_CLEAR, '0, 1'b0, 1'b0};
	bit       offer_live = 1'b0;
	int       gap_left = 0;
	int       burst_left = 0;
	int       requests_taken = 0;
	logic     rx_hold_go = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			offer_live = in_valid;
			if (in_valid && in_ready) begin
				deque_apply(offer.op, offer.val);
				requests_taken++;
				if (offer.hold_rx)
					rx_hold_go <= 1'b1;
				offer_live = 1'b0;
				// Close the burst at random and pick the next gap; a gap of zero
				// gives back-to-back stretches.
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					burst_left = $urandom_range(1, 24);
				end
			end
			if (!offer_live) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (request_q.size() != 0 &&
					!(request_q[0].wait_idle && future_results.size() != 0)) begin
					offer = next_request();
					offer_live = 1'b1;
				end
			end
			// One assignment per signal per edge; payload holds while valid is up.
			in_valid <= offer_live;
			cmd <= offer.op;
			value <= offer.val;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: stalls the output on its own pattern and checks every result.
	// ------------------------------------------------------------------
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_phase_left = 0;
	int       rx_hold_left = 0;
	bit       rx_hold_taken = 1'b0;
	int       mismatches = 0;
	int       n_elem = 0;
	int       n_err = 0;
	int       n_empty = 0;
	int       n_ovf_res = 0;
	result_t  want;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (future_results.size() == 0) begin
					$error("result with nothing expected: kind %0d value_res %h last %b",
						kind, value_res, last);
					mismatches++;
				end else begin
					want = take_result();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						mismatches++;
					end
					if (value_res !== want.val) begin
						$error("value_res: expected %h, got %h", want.val, value_res);
						mismatches++;
					end
					if (overflow_seen !== want.ovf) begin
						$error("overflow_seen: expected %b, got %b", want.ovf, overflow_seen);
						mismatches++;
					end
					if (last !== want.last) begin
						$error("last: expected %b, got %b", want.last, last);
						mismatches++;
					end
				end
				case (kind)
					KIND_ELEM:  n_elem++;
					KIND_ERROR: n_err++;
					default:    n_empty++;
				endcase
				if (overflow_seen)
					n_ovf_res++;
			end
			// Start the long hold-off once, when the driver asks for it.
			if (rx_hold_go && !rx_hold_taken) begin
				rx_hold_taken = 1'b1;
				rx_hold_left = RX_HOLD_CYCLES;
			end
			// Pick a new stall pattern when the current phase runs out.
			if (rx_phase_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				rx_phase_left = $urandom_range(20, 80);
			end else begin
				rx_phase_left--;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN:  out_ready <= 1'b1;
					RX_HALF:  out_ready <= ($urandom_range(0, 1) == 1);
					default:  out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if neither channel moves for too long.
	// ------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("deque_with_lazy_reverse_test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus plan.
	// ------------------------------------------------------------------
	int plan_cnt = 0;       // values the deque should hold inside a clean sequence
	int random_reqs = 0;    // requests that reach the deque's logic

	task automatic queue_request(input logic [CMD_W-1:0] op, input logic [VAL_W-1:0] val,
		input bit wait_idle = 1'b0, input bit hold_rx = 1'b0);
		add_request('{op, val, wait_idle, hold_rx});
		if (op <= CMD_FINISH)
			random_reqs++;
	endtask

	initial begin
		int  n;
		int  m;
		bit  big;
		bit  first_big;

		// Directed: empty finish, value extremes, reversed push/delete/drain,
		// spare codes, delete on empty and the frozen state, then clear.
		queue_request(CMD_FINISH, 16'h0000);
		queue_request(CMD_PUSH, 16'h0000);
		queue_request(CMD_PUSH, 16'hFFFF);
		queue_request(CMD_PUSH, 16'h5555);
		queue_request(CMD_PUSH, 16'hAAAA);
		queue_request(CMD_REVERSE, 16'hFFFF);
		queue_request(CMD_PUSH, 16'h1234);
		queue_request(CMD_DELETE, 16'hFFFF);
		queue_request(CMD_FINISH, 16'hFFFF);
		queue_request(CMD_PUSH, 16'h8001);
		queue_request(CMD_REVERSE, 16'h0000);
		queue_request(CMD_DELETE, 16'h0000);
		queue_request(CMD_SPARE_LO, 16'hFFFF);
		queue_request(CMD_SPARE_MID, 16'h0000);
		queue_request(CMD_SPARE_HI, 16'hFFFF);
		queue_request(CMD_DELETE, 16'h0000);
		queue_request(CMD_PUSH, 16'h7777);
		queue_request(CMD_REVERSE, 16'h0000);
		queue_request(CMD_FINISH, 16'h0000);
		queue_request(CMD_DELETE, 16'h0000);
		queue_request(CMD_CLEAR, 16'hFFFF);
		// Pause the sender until the deque has delivered everything owed.
		queue_request(CMD_FINISH, 16'h0000, 1'b1);

		// Random: mostly clean fill/drain sequences, plus noise and error runs.
		// The first clean sequence overfills the deque and its finish starts
		// the long receiver hold-off, so the drain backs up into the input.
		first_big = 1'b1;
		while (random_reqs < 330) begin
			m = $urandom_range(0, 9);
			if (m < 7) begin
				queue_request(CMD_CLEAR, VAL_W'($urandom), ($urandom_range(0, 7) == 0));
				plan_cnt = 0;
				big = first_big || ($urandom_range(0, 9) == 0);
				n = first_big ? DEPTH + 2 :
					(big ? $urandom_range(DEPTH - 4, DEPTH + 4) : $urandom_range(1, 12));
				for (int i = 0; i < n; i++) begin
					queue_request(CMD_PUSH, VAL_W'($urandom));
					if (plan_cnt < DEPTH)
						plan_cnt++;
					if ($urandom_range(0, 4) == 0)
						queue_request(CMD_REVERSE, VAL_W'($urandom));
					if (!big && plan_cnt > 0 && $urandom_range(0, 5) == 0) begin
						queue_request(CMD_DELETE, VAL_W'($urandom));
						plan_cnt--;
					end
				end
				queue_request(CMD_FINISH, VAL_W'($urandom), 1'b0, first_big);
				plan_cnt = 0;
				first_big = 1'b0;
				// Sometimes refill after the drain: head and orientation carry over.
				if ($urandom_range(0, 2) == 0) begin
					n = $urandom_range(1, 6);
					for (int i = 0; i < n; i++)
						queue_request(CMD_PUSH, VAL_W'($urandom));
					if ($urandom_range(0, 1) == 0)
						queue_request(CMD_DELETE, VAL_W'($urandom));
					queue_request(CMD_FINISH, VAL_W'($urandom));
				end
			end else if (m < 9) begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					queue_request(CMD_W'($urandom_range(0, 7)), VAL_W'($urandom));
			end else begin
				// Error run: underflow the deque, poke the frozen block, recover.
				queue_request(CMD_CLEAR, VAL_W'($urandom));
				n = $urandom_range(0, 2);
				for (int i = 0; i < n; i++)
					queue_request(CMD_PUSH, VAL_W'($urandom));
				for (int i = 0; i <= n; i++)
					queue_request(CMD_DELETE, VAL_W'($urandom));
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					queue_request(CMD_W'($urandom_range(1, 7)), VAL_W'($urandom));
				queue_request(CMD_CLEAR, VAL_W'($urandom));
			end
		end

		// Hold reset, then let the driver and monitor run.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the last request to go in and the last result to come out,
		// then give the pipeline a little longer to show any stray result.
		while (request_q.size() != 0 || in_valid)
			@(posedge clk);
		while (future_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d requests and %0d results: %0d elements, %0d delete errors, %0d empty markers",
			requests_taken, n_elem + n_err + n_empty, n_elem, n_err, n_empty);
		$display("%0d results carried the overflow flag; receiver held off %0d cycles once",
			n_ovf_res, RX_HOLD_CYCLES);
		if (mismatches == 0)
			$display("deque_with_lazy_reverse_test passed");
		else
			$display("deque_with_lazy_reverse_test failed");
		$finish;
	end

endmodule
